@@ hw/rtl/ecd_pkg.sv @@
// shared constants, types and month tables for the epoch seconds to civil date unit
`default_nettype none

package ecd_pkg;

    localparam int unsigned SECS_W = 32;

    // seconds per day is 128 * 675: low 7 bits pass through, the rest is divided by 675
    localparam logic [9:0]  DAY_DIV_HI      = 10'd675;
    localparam logic [31:0] DAY_RECIP       = 32'd3257812230;
    localparam int unsigned DAY_SHIFT       = 41;
    localparam logic [18:0] MIN_RECIP       = 19'd279620;
    localparam logic [10:0] HOUR_RECIP      = 11'd1092;
    localparam logic [15:0] PERIOD_RECIP    = 16'd45933;

    localparam logic [10:0] PERIOD_DAYS     = 11'd1461;
    localparam logic [8:0]  YEAR_DAYS       = 9'd365;
    localparam logic [15:0] FIRST_SPAN_DAYS = 16'd790;
    localparam logic [15:0] DAY_2100_MAR_01 = 16'd47541;
    localparam logic [11:0] EPOCH_YEAR      = 12'd1970;
    localparam logic [11:0] MARCH_BASE_YEAR = 12'd1972;
    localparam logic [8:0]  JAN_FIRST_DOY   = 9'd306;
    localparam logic [31:0] SECS_PER_DAY    = 32'd86400;

    typedef enum logic [1:0] {
        CAL_JAN      = 2'd0,
        CAL_JAN_LEAP = 2'd1,
        CAL_MAR      = 2'd2
    } t_cal_mode;

    typedef struct packed {
        logic              vld;
        logic [SECS_W-1:0] secs;
    } t_beat;

    // first day of year index of each month, January based or March based
    function automatic logic [8:0] month_start(t_cal_mode mode, logic [3:0] idx);
        logic [8:0] s;
        s = 9'd0;
        case (mode)
            CAL_MAR: begin
                case (idx)
                    4'd0:    s = 9'd0;
                    4'd1:    s = 9'd31;
                    4'd2:    s = 9'd61;
                    4'd3:    s = 9'd92;
                    4'd4:    s = 9'd122;
                    4'd5:    s = 9'd153;
                    4'd6:    s = 9'd184;
                    4'd7:    s = 9'd214;
                    4'd8:    s = 9'd245;
                    4'd9:    s = 9'd275;
                    4'd10:   s = 9'd306;
                    default: s = 9'd337;
                endcase
            end
            default: begin
                case (idx)
                    4'd0:    s = 9'd0;
                    4'd1:    s = 9'd31;
                    4'd2:    s = 9'd59;
                    4'd3:    s = 9'd90;
                    4'd4:    s = 9'd120;
                    4'd5:    s = 9'd151;
                    4'd6:    s = 9'd181;
                    4'd7:    s = 9'd212;
                    4'd8:    s = 9'd243;
                    4'd9:    s = 9'd273;
                    4'd10:   s = 9'd304;
                    default: s = 9'd334;
                endcase
                if (mode == CAL_JAN_LEAP && idx >= 4'd2) begin
                    s = s + 9'd1;
                end
            end
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ecd_skid.sv @@
// input skid buffer and first pipeline register of the conversion unit
`default_nettype none

module ecd_skid (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [ecd_pkg::SECS_W-1:0]  i_secs,
    input  wire logic                        i_adv,
    output logic                             o_stall,
    output ecd_pkg::t_beat                   o_beat
);

    logic                       r_skid_v;
    logic [ecd_pkg::SECS_W-1:0] r_skid_secs;
    ecd_pkg::t_beat             r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v   <= 1'b0;
            r_beat.vld <= 1'b0;
        end else if (i_adv) begin
            // skid entry goes first, no input transfer while it is held
            r_beat.vld  <= r_skid_v | i_valid;
            r_beat.secs <= r_skid_v ? r_skid_secs : i_secs;
            r_skid_v    <= 1'b0;
        end else if (i_valid && !r_skid_v) begin
            r_skid_v    <= 1'b1;
            r_skid_secs <= i_secs;
        end
    end

    assign o_stall = r_skid_v;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

@@ hw/rtl/epoch_seconds_to_civil_date_unit.sv @@
// an input transfer reaches o_valid through the skid output register and then r_s1 to r_s9
// throughput: one conversion per cycle while the output is not stalled, set by the ten-register pipeline with no loops
// a stall on the output freezes the whole pipeline, a skid entry absorbs one input transfer
// reset: synchronous active-low i_rst_n clears all valid bits and the skid entry
// the unit keeps no state between items
`default_nettype none

module epoch_seconds_to_civil_date_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [ecd_pkg::SECS_W-1:0]  i_epoch_seconds,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [5:0]                       o_second_of_minute,
    output logic [5:0]                       o_minute_of_hour,
    output logic [4:0]                       o_hour_of_day,
    output logic [4:0]                       o_day_of_month,
    output logic [3:0]                       o_month_number,
    output logic [11:0]                      o_year_number,
    output logic                             o_is_epoch_day
);

    typedef struct packed {
        logic        vld;
        logic [56:0] prod;
        logic [24:0] x;
        logic [6:0]  lo;
        logic        epoch;
    } t_s1;

    typedef struct packed {
        logic        vld;
        logic [15:0] q0;
        logic [10:0] rx;
        logic [6:0]  lo;
        logic        epoch;
    } t_s2;

    typedef struct packed {
        logic        vld;
        logic [15:0] days;
        logic [16:0] rem;
        logic        epoch;
    } t_s3;

    typedef struct packed {
        logic        vld;
        logic [35:0] sprod;
        logic [16:0] rem;
        logic        early;
        logic [1:0]  ey;
        logic [8:0]  edoy;
        logic [15:0] d;
        logic        epoch;
    } t_s4;

    typedef struct packed {
        logic        vld;
        logic [10:0] mins0;
        logic [6:0]  sraw;
        logic [31:0] pprod;
        logic [15:0] d;
        logic        early;
        logic [1:0]  ey;
        logic [8:0]  edoy;
        logic        epoch;
    } t_s5;

    typedef struct packed {
        logic        vld;
        logic [5:0]  sec;
        logic [10:0] mins;
        logic [21:0] hprod;
        logic [5:0]  p0;
        logic [11:0] rp;
        logic        early;
        logic [1:0]  ey;
        logic [8:0]  edoy;
        logic        epoch;
    } t_s6;

    typedef struct packed {
        logic        vld;
        logic [5:0]  sec;
        logic [4:0]  h0;
        logic [6:0]  mraw;
        logic [5:0]  period;
        logic [10:0] r;
        logic        early;
        logic [1:0]  ey;
        logic [8:0]  edoy;
        logic        epoch;
    } t_s7;

    typedef struct packed {
        logic               vld;
        logic [5:0]         sec;
        logic [5:0]         minute;
        logic [4:0]         hour;
        ecd_pkg::t_cal_mode mode;
        logic [8:0]         doy;
        logic [11:0]        ybase;
        logic               epoch;
    } t_s8;

    typedef struct packed {
        logic        vld;
        logic [5:0]  sec;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  mday;
        logic [3:0]  month;
        logic [11:0] year;
        logic        epoch;
    } t_s9;

    logic           en;
    ecd_pkg::t_beat in_beat;

    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    t_s4 r_s4, n_s4;
    t_s5 r_s5, n_s5;
    t_s6 r_s6, n_s6;
    t_s7 r_s7, n_s7;
    t_s8 r_s8, n_s8;
    t_s9 r_s9, n_s9;

    assign en = !(r_s9.vld && i_stall);

    ecd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_secs  (i_epoch_seconds),
        .i_adv   (en),
        .o_stall (o_stall),
        .o_beat  (in_beat)
    );

    // day count: reciprocal product
    always_comb begin
        n_s1.vld   = in_beat.vld;
        n_s1.x     = in_beat.secs[31:7];
        n_s1.lo    = in_beat.secs[6:0];
        n_s1.prod  = {32'd0, in_beat.secs[31:7]} * {25'd0, ecd_pkg::DAY_RECIP};
        n_s1.epoch = in_beat.secs < ecd_pkg::SECS_PER_DAY;
    end

    // quotient estimate and raw remainder
    always_comb begin
        logic [25:0] qm;
        qm         = {10'd0, r_s1.prod[56:41]} * {16'd0, ecd_pkg::DAY_DIV_HI};
        n_s2.vld   = r_s1.vld;
        n_s2.q0    = r_s1.prod[56:41];
        n_s2.rx    = 11'({1'b0, r_s1.x} - qm);
        n_s2.lo    = r_s1.lo;
        n_s2.epoch = r_s1.epoch;
    end

    // quotient correction, seconds within the day
    always_comb begin
        logic       c;
        logic [10:0] rxc;
        c          = r_s2.rx >= {1'b0, ecd_pkg::DAY_DIV_HI};
        rxc        = c ? (r_s2.rx - {1'b0, ecd_pkg::DAY_DIV_HI}) : r_s2.rx;
        n_s3.vld   = r_s2.vld;
        n_s3.days  = r_s2.q0 + {15'd0, c};
        n_s3.rem   = {rxc[9:0], r_s2.lo};
        n_s3.epoch = r_s2.epoch;
    end

    // minute product, first span split and period day offset
    always_comb begin
        logic [15:0] ysub;
        logic        adj;
        n_s4.vld   = r_s3.vld;
        n_s4.sprod = {19'd0, r_s3.rem} * {17'd0, ecd_pkg::MIN_RECIP};
        n_s4.rem   = r_s3.rem;
        n_s4.early = r_s3.days < ecd_pkg::FIRST_SPAN_DAYS;
        if (r_s3.days >= 16'd730) begin
            n_s4.ey = 2'd2;
            ysub    = 16'd730;
        end else if (r_s3.days >= {7'd0, ecd_pkg::YEAR_DAYS}) begin
            n_s4.ey = 2'd1;
            ysub    = {7'd0, ecd_pkg::YEAR_DAYS};
        end else begin
            n_s4.ey = 2'd0;
            ysub    = 16'd0;
        end
        n_s4.edoy  = 9'(r_s3.days - ysub);
        // 2100 has no leap day: skip it from 1 March 2100 on
        adj        = r_s3.days >= ecd_pkg::DAY_2100_MAR_01;
        n_s4.d     = r_s3.days + {15'd0, adj} - ecd_pkg::FIRST_SPAN_DAYS;
        n_s4.epoch = r_s3.epoch;
    end

    // minute estimate, raw second, period product
    always_comb begin
        logic [16:0] mm;
        mm         = {6'd0, r_s4.sprod[34:24]} * 17'd60;
        n_s5.vld   = r_s4.vld;
        n_s5.mins0 = r_s4.sprod[34:24];
        n_s5.sraw  = 7'(r_s4.rem - mm);
        n_s5.pprod = {16'd0, r_s4.d} * {16'd0, ecd_pkg::PERIOD_RECIP};
        n_s5.d     = r_s4.d;
        n_s5.early = r_s4.early;
        n_s5.ey    = r_s4.ey;
        n_s5.edoy  = r_s4.edoy;
        n_s5.epoch = r_s4.epoch;
    end

    // second correction, hour product, period estimate
    always_comb begin
        logic        sc;
        logic [15:0] pm;
        sc         = r_s5.sraw >= 7'd60;
        pm         = {10'd0, r_s5.pprod[31:26]} * {5'd0, ecd_pkg::PERIOD_DAYS};
        n_s6.vld   = r_s5.vld;
        n_s6.sec   = sc ? 6'(r_s5.sraw - 7'd60) : r_s5.sraw[5:0];
        n_s6.mins  = r_s5.mins0 + {10'd0, sc};
        n_s6.hprod = {11'd0, n_s6.mins} * {11'd0, ecd_pkg::HOUR_RECIP};
        n_s6.p0    = r_s5.pprod[31:26];
        n_s6.rp    = 12'(r_s5.d - pm);
        n_s6.early = r_s5.early;
        n_s6.ey    = r_s5.ey;
        n_s6.edoy  = r_s5.edoy;
        n_s6.epoch = r_s5.epoch;
    end

    // hour estimate, raw minute, period correction
    always_comb begin
        logic        pc;
        logic [10:0] hm;
        hm          = {6'd0, r_s6.hprod[20:16]} * 11'd60;
        pc          = r_s6.rp >= {1'b0, ecd_pkg::PERIOD_DAYS};
        n_s7.vld    = r_s6.vld;
        n_s7.sec    = r_s6.sec;
        n_s7.h0     = r_s6.hprod[20:16];
        n_s7.mraw   = 7'(r_s6.mins - hm);
        n_s7.period = r_s6.p0 + {5'd0, pc};
        n_s7.r      = pc ? 11'(r_s6.rp - {1'b0, ecd_pkg::PERIOD_DAYS}) : r_s6.rp[10:0];
        n_s7.early  = r_s6.early;
        n_s7.ey     = r_s6.ey;
        n_s7.edoy   = r_s6.edoy;
        n_s7.epoch  = r_s6.epoch;
    end

    // hour correction, year within the period (leap day stays in the last year)
    always_comb begin
        logic        hc;
        logic [1:0]  y;
        logic [10:0] ysub;
        hc = r_s7.mraw >= 7'd60;
        if (r_s7.r >= 11'd1095) begin
            y    = 2'd3;
            ysub = 11'd1095;
        end else if (r_s7.r >= 11'd730) begin
            y    = 2'd2;
            ysub = 11'd730;
        end else if (r_s7.r >= {2'd0, ecd_pkg::YEAR_DAYS}) begin
            y    = 2'd1;
            ysub = {2'd0, ecd_pkg::YEAR_DAYS};
        end else begin
            y    = 2'd0;
            ysub = 11'd0;
        end
        n_s8.vld    = r_s7.vld;
        n_s8.sec    = r_s7.sec;
        n_s8.hour   = r_s7.h0 + {4'd0, hc};
        n_s8.minute = hc ? 6'(r_s7.mraw - 7'd60) : r_s7.mraw[5:0];
        if (r_s7.early) begin
            n_s8.mode  = (r_s7.ey == 2'd2) ? ecd_pkg::CAL_JAN_LEAP : ecd_pkg::CAL_JAN;
            n_s8.doy   = r_s7.edoy;
            n_s8.ybase = ecd_pkg::EPOCH_YEAR + {10'd0, r_s7.ey};
        end else begin
            n_s8.mode  = ecd_pkg::CAL_MAR;
            n_s8.doy   = 9'(r_s7.r - ysub);
            n_s8.ybase = ecd_pkg::MARCH_BASE_YEAR + {4'd0, r_s7.period, 2'b00}
                         + {10'd0, y};
        end
        n_s8.epoch  = r_s7.epoch;
    end

    // month lookup, day of month, 1 January goes to the new year
    always_comb begin
        logic [3:0] idx;
        logic [8:0] md;
        logic       newyr;
        idx = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (r_s8.doy >= ecd_pkg::month_start(r_s8.mode, 4'(k))) begin
                idx = 4'(k);
            end
        end
        md    = r_s8.doy - ecd_pkg::month_start(r_s8.mode, idx) + 9'd1;
        newyr = (r_s8.mode == ecd_pkg::CAL_MAR) && (r_s8.doy >= ecd_pkg::JAN_FIRST_DOY);
        n_s9.vld    = r_s8.vld;
        n_s9.sec    = r_s8.sec;
        n_s9.minute = r_s8.minute;
        n_s9.hour   = r_s8.hour;
        n_s9.mday   = md[4:0];
        if (r_s8.mode == ecd_pkg::CAL_MAR) begin
            n_s9.month = (idx < 4'd10) ? (idx + 4'd3) : (idx - 4'd9);
        end else begin
            n_s9.month = idx + 4'd1;
        end
        n_s9.year   = r_s8.ybase + {11'd0, newyr};
        n_s9.epoch  = r_s8.epoch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
            r_s3.vld <= 1'b0;
            r_s4.vld <= 1'b0;
            r_s5.vld <= 1'b0;
            r_s6.vld <= 1'b0;
            r_s7.vld <= 1'b0;
            r_s8.vld <= 1'b0;
            r_s9.vld <= 1'b0;
        end else if (en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            r_s5 <= n_s5;
            r_s6 <= n_s6;
            r_s7 <= n_s7;
            r_s8 <= n_s8;
            r_s9 <= n_s9;
        end
    end

    assign o_valid            = r_s9.vld;
    assign o_second_of_minute = r_s9.sec;
    assign o_minute_of_hour   = r_s9.minute;
    assign o_hour_of_day      = r_s9.hour;
    assign o_day_of_month     = r_s9.mday;
    assign o_month_number     = r_s9.month;
    assign o_year_number      = r_s9.year;
    assign o_is_epoch_day     = r_s9.epoch;

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("skid entry taken while the pipeline was moving");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour_of_day < 5'd24) && (o_minute_of_hour < 6'd60)
                    && (o_second_of_minute < 6'd60))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month_number >= 4'd1) && (o_month_number <= 4'd12)
                    && (o_day_of_month >= 5'd1) && (o_year_number >= 12'd1970)
                    && (o_year_number <= 12'd2106))
        else $error("date out of range");

    a_epoch_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_epoch_day) |-> (o_year_number == 12'd1970)
                    && (o_month_number == 4'd1) && (o_day_of_month == 5'd1))
        else $error("epoch flag on a date other than 1 January 1970");

endmodule

`default_nettype wire
